[hdl/i2c_master_byte_engine_unit_defines.svh]
// Assertion macros for the I2C master byte engine.
// Included by the top level; no other dependencies.
`ifndef I2C_MASTER_BYTE_ENGINE_UNIT_DEFINES_SVH
`define I2C_MASTER_BYTE_ENGINE_UNIT_DEFINES_SVH

// same-cycle implication
`define I2CM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("i2cm assertion failed");

// next-cycle implication
`define I2CM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("i2cm assertion failed");

`endif

[hdl/i2cm_pkg.sv]
// Shared types and constants for the I2C master byte engine.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package i2cm_pkg;

  localparam int TIMER_BITS_DEF   = 16;
  localparam int STRETCH_BITS_DEF = 20;

  localparam int HALF_W   = 16;
  localparam int LIMIT_W  = 20;
  localparam int POLL_W   = 16;
  localparam int CFG_W    = 20;
  localparam int CFG_IDX_W = 2;

  localparam logic [HALF_W-1:0]  HALF_RST  = 16'd5;
  localparam logic [LIMIT_W-1:0] LIMIT_RST = 20'd1000;
  localparam logic [POLL_W-1:0]  POLL_RST  = 16'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HALF_PERIOD   = 2'd0,
    CFG_STRETCH_LIMIT = 2'd1,
    CFG_STRETCH_POLL  = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    FUNC_NONE  = 3'd0,
    FUNC_START = 3'd1,
    FUNC_WRITE = 3'd2,
    FUNC_READ  = 3'd3,
    FUNC_STOP  = 3'd4
  } func_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BUS_BUSY  = 2'd1,
    ST_TIMEOUT   = 2'd2,
    ST_SDA_STUCK = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    PH_IDLE         = 5'd0,
    PH_START_CHECK  = 5'd1,
    PH_START_HOLD   = 5'd2,
    PH_WB_SETUP     = 5'd3,
    PH_WB_HIGH      = 5'd4,
    PH_WB_STRETCH   = 5'd5,
    PH_RB_SETUP     = 5'd6,
    PH_RB_STRETCH   = 5'd7,
    PH_RB_HIGH      = 5'd8,
    PH_STOP_SETUP   = 5'd9,
    PH_STOP_STRETCH = 5'd10,
    PH_STOP_HOLD    = 5'd11,
    PH_STOP_RELEASE = 5'd12,
    PH_STOP_TAIL    = 5'd13
  } phase_e;

  typedef enum logic [1:0] {
    STR_COUNT   = 2'd0,
    STR_POLL    = 2'd1,
    STR_RELEASE = 2'd2,
    STR_TIMEOUT = 2'd3
  } str_res_e;

  typedef struct packed {
    logic [HALF_W-1:0]  half_period;
    logic [LIMIT_W-1:0] stretch_limit;
    logic [POLL_W-1:0]  stretch_poll;
  } cfg_t;

  typedef struct packed {
    logic [2:0] func;
    logic [6:0] address;
    logic       rw;
    logic [7:0] wdata;
    logic       send_ack;
    logic       scl_in;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic       scl_low;
    logic       sda_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rdata;
    logic       nack;
    logic [1:0] status;
  } res_t;

endpackage

`default_nettype wire

[hdl/i2cm_ifs.sv]
// Valid/ready channel interfaces for tick items and tick results.
// Depends on i2cm_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface i2cm_item_if import i2cm_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [2:0] func;
  logic [6:0] address;
  logic       rw;
  logic [7:0] wdata;
  logic       send_ack;
  logic       scl_in;
  logic       sda_in;

  modport source (output valid, func, address, rw, wdata, send_ack, scl_in, sda_in,
                  input ready);
  modport sink   (input valid, func, address, rw, wdata, send_ack, scl_in, sda_in,
                  output ready);
endinterface

interface i2cm_res_if import i2cm_pkg::*; ();
  logic       valid;
  logic       ready;
  logic       scl_low;
  logic       sda_low;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rdata;
  logic       nack;
  logic [1:0] status;

  modport source (output valid, scl_low, sda_low, busy_res, done_res, rdata, nack, status,
                  input ready);
  modport sink   (input valid, scl_low, sda_low, busy_res, done_res, rdata, nack, status,
                  output ready);
endinterface

`default_nettype wire

[hdl/i2c_master_byte_engine_unit.sv]
// Top level of the I2C master byte engine: config registers, input
// register, sequencer, result register. Depends on i2cm_pkg, the channel
// interfaces, i2cm_in_stage, i2cm_seq, i2cm_out_stage and the defines header.
//
//  channel  | dir | payload
//  ---------+-----+------------------------------------------------------
//  item_i   | in  | func address rw wdata send_ack scl_in sda_in
//  res_o    | out | scl_low sda_low busy_res done_res rdata nack status
//  cfg_*    | in  | cfg_we_i, cfg_idx_i, cfg_wdata_i (write only)
//
// One tick transfer in, one result out; one per cycle sustained while the
// result side is ready. The path runs through the input register, then the
// sequencer step into the result register. A stalled result holds the
// sequencer; the input register still takes one more transfer. Reset is
// asynchronous, active low, and loads the default timing registers; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "i2c_master_byte_engine_unit_defines.svh"

module i2c_master_byte_engine_unit import i2cm_pkg::*; #(
  parameter int TIMER_BITS   = TIMER_BITS_DEF,
  parameter int STRETCH_BITS = STRETCH_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  i2cm_item_if.sink                 item_i,
  i2cm_res_if.source                res_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_wdata_i
);

  cfg_t  cfg_q, cfg_d;
  logic  in_valid;
  item_t in_item;
  logic  out_free;
  logic  take;
  res_t  step_res;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_HALF_PERIOD:   cfg_d.half_period   = cfg_wdata_i[HALF_W-1:0];
        CFG_STRETCH_LIMIT: cfg_d.stretch_limit = cfg_wdata_i[LIMIT_W-1:0];
        CFG_STRETCH_POLL:  cfg_d.stretch_poll  = cfg_wdata_i[POLL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{half_period: HALF_RST, stretch_limit: LIMIT_RST, stretch_poll: POLL_RST};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign take = in_valid && out_free;

  i2cm_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_i),
    .take_i  (take),
    .valid_o (in_valid),
    .item_o  (in_item)
  );

  i2cm_seq #(
    .TIMER_BITS   (TIMER_BITS),
    .STRETCH_BITS (STRETCH_BITS)
  ) u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (take),
    .item_i (in_item),
    .cfg_i  (cfg_q),
    .res_o  (step_res)
  );

  i2cm_out_stage u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (take),
    .res_i  (step_res),
    .free_o (out_free),
    .res_o  (res_o)
  );

  `I2CM_ASSERT_NOW(a_done_not_busy, clk_i, rst_ni, res_o.valid && res_o.done_res, !res_o.busy_res)
  `I2CM_ASSERT_NOW(a_ready_when_empty, clk_i, rst_ni, !res_o.valid, item_i.ready)
  `I2CM_ASSERT_NEXT(a_drain, clk_i, rst_ni, res_o.valid && res_o.ready && !take, !res_o.valid)

endmodule

`default_nettype wire

[hdl/i2cm_in_stage.sv]
// Input register for tick items.
// Depends on i2cm_pkg and i2cm_item_if.
`timescale 1ns / 1ps
`default_nettype none

module i2cm_in_stage import i2cm_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  i2cm_item_if.sink  item_i,
  input  wire logic  take_i,
  output logic       valid_o,
  output item_t      item_o
);

  logic  valid_q, valid_d;
  item_t item_q;
  logic  load;

  assign item_i.ready = !valid_q || take_i;
  assign load         = item_i.valid && item_i.ready;
  assign valid_d      = load || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= '{func: item_i.func, address: item_i.address, rw: item_i.rw,
                  wdata: item_i.wdata, send_ack: item_i.send_ack,
                  scl_in: item_i.scl_in, sda_in: item_i.sda_in};
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

[hdl/i2cm_seq.sv]
// Phase sequencer, bit timers, shift register and held results.
// Depends on i2cm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i2cm_seq import i2cm_pkg::*; #(
  parameter int TIMER_BITS   = TIMER_BITS_DEF,
  parameter int STRETCH_BITS = STRETCH_BITS_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  en_i,
  input  wire item_t item_i,
  input  wire cfg_t  cfg_i,
  output res_t       res_o
);

  localparam int WideW = (STRETCH_BITS > TIMER_BITS) ? STRETCH_BITS : TIMER_BITS;
  localparam int SumW  = ((WideW > LIMIT_W) ? WideW : LIMIT_W) + 1;
  localparam logic [32:0]     TimerMax   = (33'd1 << TIMER_BITS) - 33'd1;
  localparam logic [SumW-1:0] StretchMax = (SumW'(1) << STRETCH_BITS) - SumW'(1);

  phase_e                  phase_q, phase_d;
  logic [3:0]              bc_q, bc_d;
  logic [TIMER_BITS-1:0]   half_q, half_d;
  logic [STRETCH_BITS-1:0] str_q, str_d;
  logic [7:0]              shift_q, shift_d;
  logic                    scl_q, scl_d;
  logic                    sda_q, sda_d;
  logic                    ack_q, ack_d;
  func_e                   kind_q, kind_d;
  logic [7:0]              rdata_q, rdata_d;
  logic                    nack_q, nack_d;
  status_e                 status_q, status_d;
  logic                    done_d;

  logic [TIMER_BITS-1:0]   hp_fit, poll_fit, half_dec;
  logic                    half_done;
  logic [SumW-1:0]         str_sum;
  logic [STRETCH_BITS-1:0] str_sat;
  str_res_e                str_res;
  logic [3:0]              bc_inc;
  logic                    scl, sda;

  function automatic logic [TIMER_BITS-1:0] fit_timer(input logic [15:0] v);
    logic [32:0] w;
    w = (v == 16'd0) ? 33'd1 : 33'(v);
    if (w > TimerMax) begin
      fit_timer = TimerMax[TIMER_BITS-1:0];
    end else begin
      fit_timer = w[TIMER_BITS-1:0];
    end
  endfunction

  assign scl       = item_i.scl_in;
  assign sda       = item_i.sda_in;
  assign hp_fit    = fit_timer(cfg_i.half_period);
  assign poll_fit  = fit_timer(cfg_i.stretch_poll);
  assign half_done = half_q <= TIMER_BITS'(1);
  assign half_dec  = half_q - TIMER_BITS'(1);
  assign bc_inc    = bc_q + 4'd1;
  assign str_sum   = SumW'(str_q) + SumW'(poll_fit);
  assign str_sat   = (str_sum > StretchMax) ? StretchMax[STRETCH_BITS-1:0]
                                            : str_sum[STRETCH_BITS-1:0];

  always_comb begin
    if (half_q != '0) begin
      str_res = STR_COUNT;
    end else if (scl) begin
      str_res = STR_RELEASE;
    end else if (str_sum >= SumW'(cfg_i.stretch_limit)) begin
      str_res = STR_TIMEOUT;
    end else begin
      str_res = STR_POLL;
    end
  end

  // next phase
  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      PH_IDLE: begin
        unique case (item_i.func)
          FUNC_START: phase_d = PH_START_CHECK;
          FUNC_WRITE: phase_d = PH_WB_SETUP;
          FUNC_READ:  phase_d = PH_RB_SETUP;
          FUNC_STOP:  phase_d = PH_STOP_SETUP;
          default:    phase_d = PH_IDLE;
        endcase
      end
      PH_START_CHECK: phase_d = sda ? PH_START_HOLD : PH_IDLE;
      PH_START_HOLD:  if (half_done) phase_d = PH_WB_SETUP;
      PH_WB_SETUP:    if (half_done) phase_d = PH_WB_HIGH;
      PH_WB_HIGH:     if (half_done) phase_d = PH_WB_STRETCH;
      PH_WB_STRETCH: begin
        if (str_res == STR_TIMEOUT) begin
          phase_d = PH_IDLE;
        end else if (str_res == STR_RELEASE) begin
          if (kind_q == FUNC_READ) phase_d = PH_IDLE;
          else if (bc_inc[3])      phase_d = PH_RB_SETUP;
          else                     phase_d = PH_WB_SETUP;
        end
      end
      PH_RB_SETUP: if (half_done) phase_d = PH_RB_STRETCH;
      PH_RB_STRETCH: begin
        if (str_res == STR_TIMEOUT)      phase_d = PH_IDLE;
        else if (str_res == STR_RELEASE) phase_d = PH_RB_HIGH;
      end
      PH_RB_HIGH: begin
        if (half_done) begin
          if (kind_q != FUNC_READ) phase_d = PH_IDLE;
          else if (bc_inc[3])      phase_d = PH_WB_SETUP;
          else                     phase_d = PH_RB_SETUP;
        end
      end
      PH_STOP_SETUP: if (half_done) phase_d = PH_STOP_STRETCH;
      PH_STOP_STRETCH: begin
        if (str_res == STR_TIMEOUT)      phase_d = PH_IDLE;
        else if (str_res == STR_RELEASE) phase_d = PH_STOP_HOLD;
      end
      PH_STOP_HOLD:    if (half_done) phase_d = PH_STOP_RELEASE;
      PH_STOP_RELEASE: if (half_done) phase_d = sda ? PH_STOP_TAIL : PH_IDLE;
      PH_STOP_TAIL:    if (half_done) phase_d = PH_IDLE;
      default:         phase_d = PH_IDLE;
    endcase
  end

  // datapath and held results
  always_comb begin
    bc_d     = bc_q;
    half_d   = half_q;
    str_d    = str_q;
    shift_d  = shift_q;
    scl_d    = scl_q;
    sda_d    = sda_q;
    ack_d    = ack_q;
    kind_d   = kind_q;
    rdata_d  = rdata_q;
    nack_d   = nack_q;
    status_d = status_q;
    done_d   = 1'b0;

    // shared stretch bookkeeping; release is handled per phase
    if (phase_q == PH_WB_STRETCH || phase_q == PH_RB_STRETCH ||
        phase_q == PH_STOP_STRETCH) begin
      unique case (str_res)
        STR_COUNT: half_d = half_q - TIMER_BITS'(1);
        STR_POLL: begin
          str_d  = str_sat;
          half_d = poll_fit - TIMER_BITS'(1);
        end
        STR_TIMEOUT: begin
          str_d    = str_sat;
          status_d = ST_TIMEOUT;
          done_d   = 1'b1;
        end
        STR_RELEASE: ;
      endcase
    end

    unique case (phase_q)
      PH_IDLE: begin
        unique case (item_i.func)
          FUNC_START: begin
            kind_d  = FUNC_START;
            shift_d = {item_i.address, item_i.rw};
            sda_d   = 1'b0;
          end
          FUNC_WRITE: begin
            kind_d  = FUNC_WRITE;
            shift_d = item_i.wdata;
            bc_d    = 4'd0;
            sda_d   = !item_i.wdata[7];
            half_d  = hp_fit;
          end
          FUNC_READ: begin
            kind_d  = FUNC_READ;
            ack_d   = item_i.send_ack;
            shift_d = 8'd0;
            bc_d    = 4'd0;
            sda_d   = 1'b0;
            half_d  = hp_fit;
          end
          FUNC_STOP: begin
            kind_d = FUNC_STOP;
            sda_d  = 1'b1;
            half_d = hp_fit;
          end
          default: ;
        endcase
      end
      PH_START_CHECK: begin
        if (!sda) begin
          status_d = ST_BUS_BUSY;
          done_d   = 1'b1;
        end else begin
          sda_d  = 1'b1;
          half_d = hp_fit;
        end
      end
      PH_START_HOLD: begin
        if (half_done) begin
          scl_d  = 1'b1;
          bc_d   = 4'd0;
          sda_d  = (kind_q == FUNC_READ) ? ack_q : !shift_q[7];
          half_d = hp_fit;
        end else begin
          half_d = half_dec;
        end
      end
      PH_WB_SETUP: begin
        if (half_done) begin
          scl_d  = 1'b0;
          half_d = hp_fit;
        end else begin
          half_d = half_dec;
        end
      end
      PH_WB_HIGH, PH_RB_SETUP, PH_STOP_SETUP: begin
        if (half_done) begin
          if (phase_q != PH_WB_HIGH) scl_d = 1'b0;
          half_d = '0;
          str_d  = '0;
        end else begin
          half_d = half_dec;
        end
      end
      PH_WB_STRETCH: begin
        if (str_res == STR_RELEASE) begin
          scl_d = 1'b1;
          if (kind_q == FUNC_READ) begin
            rdata_d  = shift_q;
            status_d = ST_OK;
            done_d   = 1'b1;
          end else begin
            shift_d = {shift_q[6:0], 1'b0};
            bc_d    = bc_inc;
            sda_d   = bc_inc[3] ? 1'b0 : !shift_q[6];
            half_d  = hp_fit;
          end
        end
      end
      PH_RB_STRETCH, PH_STOP_STRETCH: begin
        if (str_res == STR_RELEASE) half_d = hp_fit;
      end
      PH_RB_HIGH: begin
        if (half_done) begin
          scl_d = 1'b1;
          if (kind_q == FUNC_READ) begin
            shift_d = {shift_q[6:0], sda};
            bc_d    = bc_inc;
            sda_d   = bc_inc[3] ? ack_q : 1'b0;
            half_d  = hp_fit;
          end else begin
            nack_d   = sda;
            status_d = ST_OK;
            done_d   = 1'b1;
          end
        end else begin
          half_d = half_dec;
        end
      end
      PH_STOP_HOLD: begin
        if (half_done) begin
          sda_d  = 1'b0;
          half_d = hp_fit;
        end else begin
          half_d = half_dec;
        end
      end
      PH_STOP_RELEASE: begin
        if (half_done) begin
          if (!sda) begin
            status_d = ST_SDA_STUCK;
            done_d   = 1'b1;
          end else begin
            half_d = hp_fit;
          end
        end else begin
          half_d = half_dec;
        end
      end
      PH_STOP_TAIL: begin
        if (half_done) begin
          status_d = ST_OK;
          done_d   = 1'b1;
        end else begin
          half_d = half_dec;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      bc_q     <= '0;
      half_q   <= '0;
      str_q    <= '0;
      shift_q  <= '0;
      scl_q    <= 1'b0;
      sda_q    <= 1'b0;
      ack_q    <= 1'b0;
      kind_q   <= FUNC_NONE;
      rdata_q  <= '0;
      nack_q   <= 1'b0;
      status_q <= ST_OK;
    end else if (en_i) begin
      phase_q  <= phase_d;
      bc_q     <= bc_d;
      half_q   <= half_d;
      str_q    <= str_d;
      shift_q  <= shift_d;
      scl_q    <= scl_d;
      sda_q    <= sda_d;
      ack_q    <= ack_d;
      kind_q   <= kind_d;
      rdata_q  <= rdata_d;
      nack_q   <= nack_d;
      status_q <= status_d;
    end
  end

  assign res_o = '{scl_low: scl_d, sda_low: sda_d, busy_res: (phase_d != PH_IDLE),
                   done_res: done_d, rdata: rdata_d, nack: nack_d, status: status_d};

endmodule

`default_nettype wire

[hdl/i2cm_out_stage.sv]
// Result register driving the result channel.
// Depends on i2cm_pkg and i2cm_res_if.
`timescale 1ns / 1ps
`default_nettype none

module i2cm_out_stage import i2cm_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  load_i,
  input  wire res_t  res_i,
  output logic       free_o,
  i2cm_res_if.source res_o
);

  logic valid_q, valid_d;
  res_t res_q;

  assign free_o  = !valid_q || res_o.ready;
  assign valid_d = load_i || (valid_q && !res_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign res_o.valid    = valid_q;
  assign res_o.scl_low  = res_q.scl_low;
  assign res_o.sda_low  = res_q.sda_low;
  assign res_o.busy_res = res_q.busy_res;
  assign res_o.done_res = res_q.done_res;
  assign res_o.rdata    = res_q.rdata;
  assign res_o.nack     = res_q.nack;
  assign res_o.status   = res_q.status;

endmodule

`default_nettype wire

[dv/tb_i2c_master_byte_engine_unit.sv]
// Testbench for i2c_master_byte_engine_unit: sends tick transfers with modeled
// SCL/SDA levels, predicts every result tick and checks it field by field.
// Depends on i2cm_pkg, the i2cm channel interfaces and the block's RTL.
`timescale 1ns / 1ps
module tb_i2c_master_byte_engine_unit;
  import i2cm_pkg::*;

  localparam int unsigned     CYCLE_LIMIT = 2000000;
  localparam int              HOLD_CYCLES = 250;
  localparam longint unsigned WAIT_SAT    = (64'd1 << TIMER_BITS_DEF) - 1;
  localparam longint unsigned ACC_SAT     = (64'd1 << STRETCH_BITS_DEF) - 1;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_wdata_i;

  i2cm_item_if item_if ();
  i2cm_res_if  res_if ();

  i2c_master_byte_engine_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_if),
    .res_o       (res_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // engine model state
  logic [HALF_W-1:0]  cfg_half    = HALF_RST;
  logic [LIMIT_W-1:0] cfg_limit   = LIMIT_RST;
  logic [POLL_W-1:0]  cfg_poll    = POLL_RST;
  phase_e             ph          = PH_IDLE;
  logic [3:0]         bit_cnt     = '0;
  longint unsigned    wait_left   = 0;
  longint unsigned    stretch_acc = 0;
  logic [7:0]         shreg       = '0;
  logic               scl_drv     = 1'b0;
  logic               sda_drv     = 1'b0;
  logic               ack_hold    = 1'b0;
  func_e              cmd_kind    = FUNC_NONE;
  logic [7:0]         last_rdata  = '0;
  logic               last_nack   = 1'b0;
  status_e            last_status = ST_OK;
  logic               done_now    = 1'b0;

  res_t expected_bus_results[$];
  res_t exp_r;

  // stimulus knobs
  int tx_idle_pct   = 22;
  int rx_idle_pct   = 50;
  int scl_low_pct   = 30;
  int sda_fault_pct = 0;
  int busy_cmd_pct  = 0;
  int scl_hold_left = 0;
  int hold_reqs     = 0;
  int hold_taken    = 0;
  int hold_left     = 0;
  int errors        = 0;
  int unsigned ticks_sent = 0;
  int unsigned cycle_cnt  = 0;

  function automatic longint unsigned fit_ticks(longint unsigned v);
    if (v == 0) v = 1;
    return (v > WAIT_SAT) ? WAIT_SAT : v;
  endfunction

  function automatic void load_wait();
    wait_left = fit_ticks(cfg_half);
  endfunction

  function automatic bit wait_done();
    if (wait_left > 1) begin
      wait_left--;
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void enter_stretch(phase_e nxt);
    wait_left   = 0;
    stretch_acc = 0;
    ph          = nxt;
  endfunction

  function automatic str_res_e stretch_poll(logic scl);
    longint unsigned poll;
    longint unsigned sum;
    poll = fit_ticks(cfg_poll);
    if (wait_left > 0) begin
      wait_left--;
      return STR_COUNT;
    end
    if (scl) return STR_RELEASE;
    sum = stretch_acc + poll;
    stretch_acc = (sum > ACC_SAT) ? ACC_SAT : sum;
    if (sum >= cfg_limit) return STR_TIMEOUT;
    wait_left = poll - 1;
    return STR_COUNT;
  endfunction

  function automatic void end_cmd(status_e st);
    ph          = PH_IDLE;
    last_status = st;
    done_now    = 1'b1;
  endfunction

  function automatic void drive_write_bit();
    if (cmd_kind == FUNC_READ) sda_drv = ack_hold;
    else sda_drv = ~shreg[7];
    load_wait();
    ph = PH_WB_SETUP;
  endfunction

  function automatic void drive_read_bit();
    sda_drv = 1'b0;
    load_wait();
    ph = PH_RB_SETUP;
  endfunction

  function automatic res_t step_bus_engine(item_t it);
    res_t     r;
    str_res_e sr;
    done_now = 1'b0;
    case (ph)
      PH_IDLE: begin
        if (it.func == FUNC_START) begin
          cmd_kind = FUNC_START;
          shreg    = {it.address, it.rw};
          sda_drv  = 1'b0;
          ph       = PH_START_CHECK;
        end else if (it.func == FUNC_WRITE) begin
          cmd_kind = FUNC_WRITE;
          shreg    = it.wdata;
          bit_cnt  = '0;
          drive_write_bit();
        end else if (it.func == FUNC_READ) begin
          cmd_kind = FUNC_READ;
          ack_hold = it.send_ack;
          shreg    = '0;
          bit_cnt  = '0;
          drive_read_bit();
        end else if (it.func == FUNC_STOP) begin
          cmd_kind = FUNC_STOP;
          sda_drv  = 1'b1;
          load_wait();
          ph = PH_STOP_SETUP;
        end
      end
      PH_START_CHECK: begin
        if (!it.sda_in) begin
          end_cmd(ST_BUS_BUSY);
        end else begin
          sda_drv = 1'b1;
          load_wait();
          ph = PH_START_HOLD;
        end
      end
      PH_START_HOLD: begin
        if (wait_done()) begin
          scl_drv = 1'b1;
          bit_cnt = '0;
          drive_write_bit();
        end
      end
      PH_WB_SETUP: begin
        if (wait_done()) begin
          scl_drv = 1'b0;
          load_wait();
          ph = PH_WB_HIGH;
        end
      end
      PH_WB_HIGH: begin
        if (wait_done()) enter_stretch(PH_WB_STRETCH);
      end
      PH_WB_STRETCH: begin
        sr = stretch_poll(it.scl_in);
        if (sr == STR_TIMEOUT) begin
          end_cmd(ST_TIMEOUT);
        end else if (sr == STR_RELEASE) begin
          scl_drv = 1'b1;
          if (cmd_kind == FUNC_READ) begin
            last_rdata = shreg;
            end_cmd(ST_OK);
          end else begin
            shreg   = shreg << 1;
            bit_cnt = bit_cnt + 4'd1;
            if (bit_cnt >= 4'd8) drive_read_bit();
            else drive_write_bit();
          end
        end
      end
      PH_RB_SETUP: begin
        if (wait_done()) begin
          scl_drv = 1'b0;
          enter_stretch(PH_RB_STRETCH);
        end
      end
      PH_RB_STRETCH: begin
        sr = stretch_poll(it.scl_in);
        if (sr == STR_TIMEOUT) begin
          end_cmd(ST_TIMEOUT);
        end else if (sr == STR_RELEASE) begin
          load_wait();
          ph = PH_RB_HIGH;
        end
      end
      PH_RB_HIGH: begin
        if (wait_done()) begin
          scl_drv = 1'b1;
          if (cmd_kind == FUNC_READ) begin
            shreg   = {shreg[6:0], it.sda_in};
            bit_cnt = bit_cnt + 4'd1;
            if (bit_cnt >= 4'd8) drive_write_bit();
            else drive_read_bit();
          end else begin
            last_nack = it.sda_in;
            end_cmd(ST_OK);
          end
        end
      end
      PH_STOP_SETUP: begin
        if (wait_done()) begin
          scl_drv = 1'b0;
          enter_stretch(PH_STOP_STRETCH);
        end
      end
      PH_STOP_STRETCH: begin
        sr = stretch_poll(it.scl_in);
        if (sr == STR_TIMEOUT) begin
          end_cmd(ST_TIMEOUT);
        end else if (sr == STR_RELEASE) begin
          load_wait();
          ph = PH_STOP_HOLD;
        end
      end
      PH_STOP_HOLD: begin
        if (wait_done()) begin
          sda_drv = 1'b0;
          load_wait();
          ph = PH_STOP_RELEASE;
        end
      end
      PH_STOP_RELEASE: begin
        if (wait_done()) begin
          if (!it.sda_in) begin
            end_cmd(ST_SDA_STUCK);
          end else begin
            load_wait();
            ph = PH_STOP_TAIL;
          end
        end
      end
      PH_STOP_TAIL: begin
        if (wait_done()) end_cmd(ST_OK);
      end
      default: ph = PH_IDLE;
    endcase
    r.scl_low  = scl_drv;
    r.sda_low  = sda_drv;
    r.busy_res = (ph != PH_IDLE);
    r.done_res = done_now;
    r.rdata    = last_rdata;
    r.nack     = last_nack;
    r.status   = last_status;
    return r;
  endfunction

  // line levels as a target and the bus would present them in the next phase
  function automatic item_t bus_item();
    item_t it;
    it.func     = FUNC_NONE;
    it.address  = 7'($urandom_range(127));
    it.rw       = 1'($urandom_range(1));
    it.wdata    = 8'($urandom_range(255));
    it.send_ack = 1'($urandom_range(1));
    it.scl_in   = 1'($urandom_range(1));
    it.sda_in   = 1'($urandom_range(1));
    if (ph != PH_IDLE && $urandom_range(99) < busy_cmd_pct) it.func = 3'($urandom_range(1, 7));
    case (ph)
      PH_WB_STRETCH, PH_RB_STRETCH, PH_STOP_STRETCH: begin
        if (scl_hold_left > 0) begin
          it.scl_in = 1'b0;
          scl_hold_left--;
        end else begin
          it.scl_in = ($urandom_range(99) >= scl_low_pct);
        end
      end
      PH_START_CHECK, PH_STOP_RELEASE: it.sda_in = ($urandom_range(99) >= sda_fault_pct);
      default: ;
    endcase
    return it;
  endfunction

  task automatic send_tick(input item_t it);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      item_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    item_if.valid    <= 1'b1;
    item_if.func     <= it.func;
    item_if.address  <= it.address;
    item_if.rw       <= it.rw;
    item_if.wdata    <= it.wdata;
    item_if.send_ack <= it.send_ack;
    item_if.scl_in   <= it.scl_in;
    item_if.sda_in   <= it.sda_in;
    do @(posedge clk_i); while (!item_if.ready);
    expected_bus_results.push_back(step_bus_engine(it));
    ticks_sent++;
  endtask

  task automatic run_cmd(input func_e f, input logic [6:0] addr, input logic rw,
                         input logic [7:0] wd, input logic ack);
    item_t it;
    it          = bus_item();
    it.func     = f;
    it.address  = addr;
    it.rw       = rw;
    it.wdata    = wd;
    it.send_ack = ack;
    send_tick(it);
    while (ph != PH_IDLE) send_tick(bus_item());
  endtask

  // finish the running command on a quiet bus, then drain all results
  task automatic settle_bus();
    item_t it;
    while (ph != PH_IDLE) begin
      it        = bus_item();
      it.func   = FUNC_NONE;
      it.scl_in = 1'b1;
      it.sda_in = 1'b1;
      send_tick(it);
    end
    item_if.valid <= 1'b0;
    while (expected_bus_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_timing(input logic [CFG_W-1:0] half, input logic [CFG_W-1:0] limit,
                            input logic [CFG_W-1:0] poll);
    settle_bus();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_HALF_PERIOD;
    cfg_wdata_i <= half;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_STRETCH_LIMIT;
    cfg_wdata_i <= limit;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_STRETCH_POLL;
    cfg_wdata_i <= poll;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cfg_half  = half[HALF_W-1:0];
    cfg_limit = limit[LIMIT_W-1:0];
    cfg_poll  = poll[POLL_W-1:0];
  endtask

  task automatic test_basic_transfers();
    scl_low_pct = 30;
    run_cmd(FUNC_START, 7'h00, 1'b0, 8'h00, 1'b0);
    run_cmd(FUNC_WRITE, 7'h00, 1'b0, 8'h00, 1'b0);
    run_cmd(FUNC_WRITE, 7'h00, 1'b0, 8'hFF, 1'b0);
    run_cmd(FUNC_WRITE, 7'h00, 1'b0, 8'hA5, 1'b0);
    run_cmd(FUNC_STOP, 7'h00, 1'b0, 8'h00, 1'b0);
    run_cmd(FUNC_START, 7'h7F, 1'b1, 8'hFF, 1'b1);
    run_cmd(FUNC_READ, 7'h7F, 1'b1, 8'hFF, 1'b1);
    run_cmd(FUNC_READ, 7'h7F, 1'b1, 8'hFF, 1'b0);
    run_cmd(FUNC_STOP, 7'h7F, 1'b1, 8'hFF, 1'b1);
  endtask

  task automatic test_bus_faults();
    item_t it;
    sda_fault_pct = 100;
    run_cmd(FUNC_START, 7'h33, 1'b0, 8'h00, 1'b0);
    run_cmd(FUNC_STOP, 7'h33, 1'b0, 8'h00, 1'b0);
    sda_fault_pct = 0;
    set_timing(20'd2, 20'd6, 20'd1);
    scl_hold_left = 1000;
    run_cmd(FUNC_WRITE, 7'h00, 1'b0, 8'h81, 1'b0);
    run_cmd(FUNC_READ, 7'h00, 1'b0, 8'h00, 1'b1);
    run_cmd(FUNC_STOP, 7'h00, 1'b0, 8'h00, 1'b0);
    scl_hold_left = 0;
    busy_cmd_pct  = 100;
    run_cmd(FUNC_START, 7'h11, 1'b1, 8'h00, 1'b0);
    run_cmd(FUNC_READ, 7'h11, 1'b1, 8'h00, 1'b0);
    run_cmd(FUNC_STOP, 7'h11, 1'b1, 8'h00, 1'b0);
    busy_cmd_pct = 0;
    // unused function codes are dropped like a plain tick
    for (int f = 5; f <= 7; f++) begin
      it      = bus_item();
      it.func = 3'(f);
      send_tick(it);
    end
  endtask

  task automatic test_timing_extremes();
    set_timing(20'd0, 20'd0, 20'd0);
    scl_low_pct = 50;
    run_cmd(FUNC_START, 7'h55, 1'b0, 8'h00, 1'b0);
    run_cmd(FUNC_WRITE, 7'h55, 1'b0, 8'h3C, 1'b0);
    run_cmd(FUNC_READ, 7'h55, 1'b0, 8'h00, 1'b1);
    run_cmd(FUNC_STOP, 7'h55, 1'b0, 8'h00, 1'b0);
    set_timing(20'd1, 20'd1000000, 20'd1);
    scl_low_pct   = 0;
    scl_hold_left = 60;
    run_cmd(FUNC_STOP, 7'h00, 1'b0, 8'h00, 1'b0);
    set_timing(20'd1, 20'd1, 20'd65535);
    scl_hold_left = 2;
    run_cmd(FUNC_WRITE, 7'h00, 1'b0, 8'hC3, 1'b0);
    scl_hold_left = 0;
  endtask

  task automatic test_random_traffic(input int unsigned n_ticks);
    int unsigned stop_at;
    int unsigned seg_end;
    logic [6:0]  addr;
    logic        rw;
    int          nbytes;
    int          r;
    item_t       it;
    stop_at = ticks_sent + n_ticks;
    while (ticks_sent < stop_at) begin
      set_timing(CFG_W'($urandom_range(0, 2)),
                 CFG_W'(($urandom_range(5) == 0) ? $urandom_range(200, 1000)
                                                 : $urandom_range(0, 30)),
                 CFG_W'($urandom_range(0, 2)));
      scl_low_pct   = $urandom_range(0, 60);
      sda_fault_pct = $urandom_range(0, 20);
      busy_cmd_pct  = $urandom_range(0, 15);
      seg_end = ticks_sent + n_ticks / 3;
      while (ticks_sent < seg_end && ticks_sent < stop_at) begin
        r    = $urandom_range(99);
        addr = 7'($urandom_range(127));
        rw   = 1'($urandom_range(1));
        if (r < 75) begin
          run_cmd(FUNC_START, addr, rw, 8'($urandom_range(255)), 1'($urandom_range(1)));
          nbytes = $urandom_range(1, 3);
          for (int i = 0; i < nbytes; i++) begin
            if (rw) run_cmd(FUNC_READ, addr, rw, 8'($urandom_range(255)),
                            (i < nbytes - 1) ? 1'b1 : 1'($urandom_range(1)));
            else run_cmd(FUNC_WRITE, addr, rw, 8'($urandom_range(255)), 1'($urandom_range(1)));
          end
          run_cmd(FUNC_STOP, addr, rw, 8'($urandom_range(255)), 1'($urandom_range(1)));
        end else if (r < 92) begin
          run_cmd(func_e'($urandom_range(1, 4)), addr, rw, 8'($urandom_range(255)),
                  1'($urandom_range(1)));
        end else begin
          repeat ($urandom_range(1, 4)) begin
            it      = bus_item();
            it.func = ($urandom_range(1) != 0) ? 3'($urandom_range(5, 7)) : FUNC_NONE;
            send_tick(it);
          end
        end
      end
    end
    scl_low_pct   = 0;
    sda_fault_pct = 0;
    busy_cmd_pct  = 0;
  endtask

  task automatic test_backpressure();
    set_timing(20'd2, 20'd50, 20'd1);
    scl_low_pct = 20;
    hold_reqs++;
    run_cmd(FUNC_START, 7'h2A, 1'b0, 8'h00, 1'b0);
    run_cmd(FUNC_WRITE, 7'h2A, 1'b0, 8'h5A, 1'b0);
    run_cmd(FUNC_STOP, 7'h2A, 1'b0, 8'h00, 1'b0);
    scl_low_pct = 0;
  endtask

  task automatic test_long_waits();
    scl_low_pct = 0;
    set_timing(20'd1, 20'd1000, 20'd100);
    scl_hold_left = 1;
    run_cmd(FUNC_STOP, 7'h00, 1'b0, 8'h00, 1'b0);
    set_timing(20'd80, 20'd0, 20'd1);
    scl_hold_left = 4;
    run_cmd(FUNC_STOP, 7'h00, 1'b0, 8'h00, 1'b0);
    scl_hold_left = 0;
  endtask

  function automatic void check_field(string nm, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t mismatch %s: expected %0h actual %0h", $time, nm, want, got);
      errors++;
    end
  endfunction

  // result side: check each transfer, then pick the next ready level
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        if (expected_bus_results.size() == 0) begin
          $display("%0t unexpected result: expected none, actual status %0h busy %0h",
                   $time, res_if.status, res_if.busy_res);
          errors++;
        end else begin
          exp_r = expected_bus_results.pop_front();
          check_field("scl_low", 8'(exp_r.scl_low), 8'(res_if.scl_low));
          check_field("sda_low", 8'(exp_r.sda_low), 8'(res_if.sda_low));
          check_field("busy_res", 8'(exp_r.busy_res), 8'(res_if.busy_res));
          check_field("done_res", 8'(exp_r.done_res), 8'(res_if.done_res));
          check_field("rdata", exp_r.rdata, res_if.rdata);
          check_field("nack", 8'(exp_r.nack), 8'(res_if.nack));
          check_field("status", 8'(exp_r.status), 8'(res_if.status));
        end
      end
      if (hold_taken != hold_reqs) begin
        hold_left  = HOLD_CYCLES;
        hold_taken = hold_reqs;
      end
      if (hold_left != 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end else begin
      res_if.ready <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    rst_ni           <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_idx_i        <= CFG_HALF_PERIOD;
    cfg_wdata_i      <= '0;
    item_if.valid    <= 1'b0;
    item_if.func     <= FUNC_NONE;
    item_if.address  <= '0;
    item_if.rw       <= 1'b0;
    item_if.wdata    <= '0;
    item_if.send_ack <= 1'b0;
    item_if.scl_in   <= 1'b1;
    item_if.sda_in   <= 1'b1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    tx_idle_pct = 22;
    rx_idle_pct = 50;
    test_basic_transfers();
    test_bus_faults();
    test_timing_extremes();
    test_random_traffic(100);

    tx_idle_pct = 50;
    rx_idle_pct = 22;
    test_random_traffic(100);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_traffic(100);
    test_backpressure();
    test_long_waits();

    settle_bus();
    repeat (8) @(posedge clk_i);
    if (errors == 0 && expected_bus_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
